// ===== rtl/core/bsd_pkg.sv =====
// Shared types, constants and helpers for the backlight schedule dimmer.
// Used by bsd_ctrl, bsd_dp and backlight_schedule_dimmer_top; no dependencies.
`default_nettype none

package bsd_pkg;

  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned TIME_W    = 40;
  localparam int unsigned TOD_W     = 27;
  localparam int unsigned HOLD_W    = 22;
  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned DIFF_W    = TOD_W + 1;
  localparam int unsigned PROD_W    = DIFF_W + LEVEL_W + 1;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned IN_DATA_W = 176;
  localparam int unsigned IN_USER_W = 5;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 27;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 10'd1000;
  localparam logic [LEVEL_W-1:0] LEVEL_STEP = 10'd10;

  localparam logic [LEVEL_W-1:0] NIGHT_RST    = 10'd100;
  localparam logic [LEVEL_W-1:0] TWILIGHT_RST = 10'd400;
  localparam logic [LEVEL_W-1:0] NOON_RST     = 10'd1000;
  localparam logic [LEVEL_W-1:0] TOUCH_RST    = 10'd1000;
  localparam logic [HOLD_W-1:0]  HOLD_RST     = 22'd30000;
  localparam logic [TOD_W-1:0]   START_RST    = 27'd0;
  localparam logic [TOD_W-1:0]   END_RST      = 27'd86399999;

  localparam logic [PHASE_W-1:0] PH_MORNING   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_DAWN_ASTRO = 4'd1;
  localparam logic [PHASE_W-1:0] PH_DAWN_CIVIL = 4'd3;
  localparam logic [PHASE_W-1:0] PH_FORENOON  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_AFTERNOON = 4'd5;
  localparam logic [PHASE_W-1:0] PH_DUSK_CIVIL = 4'd6;
  localparam logic [PHASE_W-1:0] PH_DUSK_ASTRO = 4'd8;
  localparam logic [PHASE_W-1:0] PH_EVENING   = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NIGHT    = 3'd0,
    REG_TWILIGHT = 3'd1,
    REG_NOON     = 3'd2,
    REG_TOUCH    = 3'd3,
    REG_HOLD     = 3'd4,
    REG_START    = 3'd5,
    REG_END      = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_BLEND,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] night;
    logic [LEVEL_W-1:0] twilight;
    logic [LEVEL_W-1:0] noon;
    logic [LEVEL_W-1:0] touch;
    logic [HOLD_W-1:0]  hold;
    logic [TOD_W-1:0]   on_start;
    logic [TOD_W-1:0]   on_end;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic prep;
    logic div_step;
    logic blend;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_blend;
    logic div_last;
    logic out_free;
  } status_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    clamp_level = (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/backlight_schedule_dimmer_top.sv =====
// Top level of the backlight schedule dimmer: config registers, sequencer
// and datapath. Depends on bsd_pkg, bsd_ctrl, bsd_dp.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tick: times, solar times, touch, phase
//  m_*       out  m_tvalid/m_tready    display_on, power_changed, level_update, level
//  cfg_*     in   cfg_valid/cfg_ready  register index and value
//
// A tick runs evaluate and finish when no blend is needed, and also multiply,
// prepare, a 39-step restoring divide and blend when forenoon or afternoon
// interpolation runs. One tick is in flight at a time; the output register lets
// the next tick be accepted while a result waits, and the finish step holds while
// that register is still full. Reset restores the config registers, sequencer
// state, touch time, shown state and output valid. cfg_ready is always high.
`default_nettype none

module backlight_schedule_dimmer_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // now_utc_ms[39:0], zone_tod_ms[66:40], solar_now_ms[93:67],
  // solar_noon_ms[120:94], sunrise_ms[147:121], sunset_ms[174:148], zero pad
  input  wire logic [bsd_pkg::IN_DATA_W-1:0]     s_tdata,
  // touched[0], day_phase[4:1]
  input  wire logic [bsd_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // level[9:0], zero pad
  output logic [bsd_pkg::OUT_DATA_W-1:0]         m_tdata,
  // display_on[0], power_changed[1], level_update[2]
  output logic [bsd_pkg::OUT_USER_W-1:0]         m_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bsd_pkg::cfg_t    cfg;
  bsd_pkg::cmd_t    cmd;
  bsd_pkg::status_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.night    <= bsd_pkg::NIGHT_RST;
      cfg.twilight <= bsd_pkg::TWILIGHT_RST;
      cfg.noon     <= bsd_pkg::NOON_RST;
      cfg.touch    <= bsd_pkg::TOUCH_RST;
      cfg.hold     <= bsd_pkg::HOLD_RST;
      cfg.on_start <= bsd_pkg::START_RST;
      cfg.on_end   <= bsd_pkg::END_RST;
    end else if (cfg_valid) begin
      case (bsd_pkg::cfg_idx_t'(cfg_index))
        bsd_pkg::REG_NIGHT:    cfg.night    <= cfg_data[bsd_pkg::LEVEL_W-1:0];
        bsd_pkg::REG_TWILIGHT: cfg.twilight <= cfg_data[bsd_pkg::LEVEL_W-1:0];
        bsd_pkg::REG_NOON:     cfg.noon     <= cfg_data[bsd_pkg::LEVEL_W-1:0];
        bsd_pkg::REG_TOUCH:    cfg.touch    <= cfg_data[bsd_pkg::LEVEL_W-1:0];
        bsd_pkg::REG_HOLD:     cfg.hold     <= cfg_data[bsd_pkg::HOLD_W-1:0];
        bsd_pkg::REG_START:    cfg.on_start <= cfg_data[bsd_pkg::TOD_W-1:0];
        bsd_pkg::REG_END:      cfg.on_end   <= cfg_data[bsd_pkg::TOD_W-1:0];
        default: ;
      endcase
    end
  end

  bsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .st        (st),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bsd_ctrl.sv =====
// Sequencer for the dimmer: walks one tick through evaluate, then multiply,
// prepare, divide and blend if a blend is needed, and finish. Depends on bsd_pkg.
`default_nettype none

module bsd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bsd_pkg::status_t st,
  output bsd_pkg::cmd_t         cmd
);

  bsd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bsd_pkg::ST_IDLE: begin
        if (in_valid) state_next = bsd_pkg::ST_EVAL;
      end
      bsd_pkg::ST_EVAL: begin
        state_next = st.need_blend ? bsd_pkg::ST_MUL : bsd_pkg::ST_FIN;
      end
      bsd_pkg::ST_MUL:   state_next = bsd_pkg::ST_PREP;
      bsd_pkg::ST_PREP:  state_next = bsd_pkg::ST_DIV;
      bsd_pkg::ST_DIV: begin
        if (st.div_last) state_next = bsd_pkg::ST_BLEND;
      end
      bsd_pkg::ST_BLEND: state_next = bsd_pkg::ST_FIN;
      bsd_pkg::ST_FIN: begin
        if (st.out_free) state_next = bsd_pkg::ST_IDLE;
      end
      default: state_next = bsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      bsd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bsd_pkg::ST_EVAL:  cmd.eval = 1'b1;
      bsd_pkg::ST_MUL:   cmd.mul = 1'b1;
      bsd_pkg::ST_PREP:  cmd.prep = 1'b1;
      bsd_pkg::ST_DIV:   cmd.div_step = 1'b1;
      bsd_pkg::ST_BLEND: cmd.blend = 1'b1;
      bsd_pkg::ST_FIN:   cmd.finish = st.out_free;
      default: cmd = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> st.out_free)
    else $error("result written while output register still full");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");
  a_load_then_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.eval)
    else $error("accepted beat not evaluated next cycle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bsd_dp.sv =====
// Datapath of the dimmer: tick capture, touch/window/phase decision,
// blend multiplier, restoring divider, output register. Depends on bsd_pkg.
`default_nettype none

module bsd_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire bsd_pkg::cfg_t                        cfg,
  input  wire bsd_pkg::cmd_t                        cmd,
  output bsd_pkg::status_t                          st,
  input  wire logic [bsd_pkg::IN_DATA_W-1:0]        in_data,
  input  wire logic [bsd_pkg::IN_USER_W-1:0]        in_user,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [bsd_pkg::OUT_DATA_W-1:0]            out_data,
  output logic [bsd_pkg::OUT_USER_W-1:0]            out_user
);

  localparam int unsigned LW = bsd_pkg::LEVEL_W;
  localparam int unsigned TW = bsd_pkg::TOD_W;
  localparam int unsigned DW = bsd_pkg::DIFF_W;
  localparam int unsigned PW = bsd_pkg::PROD_W;

  // unpacked input fields
  logic [bsd_pkg::TIME_W-1:0]  f_now;
  logic                        f_touched;
  logic [TW-1:0]               f_tod, f_snow, f_snoon, f_srise, f_sset;
  logic [bsd_pkg::PHASE_W-1:0] f_phase;

  assign f_now     = in_data[39:0];
  assign f_tod     = in_data[66:40];
  assign f_snow    = in_data[93:67];
  assign f_snoon   = in_data[120:94];
  assign f_srise   = in_data[147:121];
  assign f_sset    = in_data[174:148];
  assign f_touched = in_user[0];
  assign f_phase   = in_user[4:1];

  // tick registers
  logic [bsd_pkg::TIME_W-1:0]  now_r, last_touch;
  logic [TW-1:0]               tod_r;
  logic [bsd_pkg::PHASE_W-1:0] phase_r;
  logic signed [DW-1:0]        num_r, den_r;
  logic signed [DW-1:0]        num_next, den_next;

  always_comb begin
    num_next = '0;
    den_next = '0;
    if (f_phase == bsd_pkg::PH_FORENOON) begin
      num_next = $signed({1'b0, f_snow})  - $signed({1'b0, f_srise});
      den_next = $signed({1'b0, f_snoon}) - $signed({1'b0, f_srise});
    end else if (f_phase == bsd_pkg::PH_AFTERNOON) begin
      num_next = $signed({1'b0, f_sset}) - $signed({1'b0, f_snow});
      den_next = $signed({1'b0, f_sset}) - $signed({1'b0, f_snoon});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_touch <= '0;
    end else if (cmd.load && f_touched) begin
      last_touch <= f_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r   <= f_now;
      tod_r   <= f_tod;
      phase_r <= f_phase;
      num_r   <= num_next;
      den_r   <= den_next;
    end
  end

  // decision
  logic          held, outside, blend_case;
  logic          on_eval;
  logic [LW-1:0] lvl_eval;

  assign held = {1'b0, now_r} <
                ({1'b0, last_touch} + {{(bsd_pkg::TIME_W+1-bsd_pkg::HOLD_W){1'b0}}, cfg.hold});
  assign outside = (tod_r < cfg.on_start) || (tod_r > cfg.on_end);

  always_comb begin
    on_eval    = 1'b1;
    lvl_eval   = '0;
    blend_case = 1'b0;
    if (held) begin
      lvl_eval = bsd_pkg::clamp_level(cfg.touch);
    end else if (outside) begin
      on_eval = 1'b0;
    end else if (phase_r == bsd_pkg::PH_MORNING || phase_r == bsd_pkg::PH_EVENING) begin
      lvl_eval = bsd_pkg::clamp_level(cfg.night);
    end else if (phase_r inside {[bsd_pkg::PH_DAWN_ASTRO:bsd_pkg::PH_DAWN_CIVIL],
                                 [bsd_pkg::PH_DUSK_CIVIL:bsd_pkg::PH_DUSK_ASTRO]}) begin
      lvl_eval = bsd_pkg::clamp_level(cfg.twilight);
    end else if (phase_r == bsd_pkg::PH_FORENOON || phase_r == bsd_pkg::PH_AFTERNOON) begin
      lvl_eval   = bsd_pkg::clamp_level(cfg.noon);
      blend_case = (den_r != '0);
    end
  end

  assign st.need_blend = blend_case;

  // blend: product, then restoring division with round-half-away
  logic signed [LW:0]   span;
  logic signed [PW-1:0] prod_full, prod_r;
  logic [PW-1:0]        ap;
  logic [DW-1:0]        ad;
  logic [PW-1:0]        quo;
  logic [DW-1:0]        divisor;
  logic [DW-1:0]        rem;
  logic [DW:0]          rem_sh, rem_sub;
  logic                 neg;
  logic [bsd_pkg::CNT_W-1:0] cnt;

  assign span      = $signed({1'b0, cfg.noon}) - $signed({1'b0, cfg.twilight});
  assign prod_full = num_r * span;
  assign ap        = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
  assign ad        = den_r[DW-1] ? DW'(-den_r) : DW'(den_r);
  assign rem_sh    = {rem, quo[PW-1]};
  assign rem_sub   = rem_sh - {1'b0, divisor};
  assign st.div_last = (cnt == bsd_pkg::CNT_W'(bsd_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= prod_full;
    if (cmd.prep) begin
      quo     <= {ap[PW-2:0], 1'b0} + {{(PW-DW){1'b0}}, ad};
      divisor <= {ad[DW-2:0], 1'b0};
      rem     <= '0;
      neg     <= prod_r[PW-1] ^ den_r[DW-1];
      cnt     <= '0;
    end else if (cmd.div_step) begin
      // shift in one dividend bit, subtract when it fits
      if (!rem_sub[DW]) begin
        rem <= rem_sub[DW-1:0];
        quo <= {quo[PW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DW-1:0];
        quo <= {quo[PW-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

  logic [PW:0]   sum_up;
  logic [LW-1:0] lvl_blend;

  assign sum_up = {1'b0, quo} + {{(PW+1-LW){1'b0}}, cfg.twilight};

  always_comb begin
    if (neg) begin
      // twilight may sit above full scale, so saturate the difference as well
      lvl_blend = (quo > {{(PW-LW){1'b0}}, cfg.twilight}) ? '0 :
                  bsd_pkg::clamp_level(LW'(cfg.twilight - quo[LW-1:0]));
    end else begin
      lvl_blend = (sum_up > {{(PW+1-LW){1'b0}}, bsd_pkg::LEVEL_MAX}) ?
                  bsd_pkg::LEVEL_MAX : sum_up[LW-1:0];
    end
  end

  logic          on_r;
  logic [LW-1:0] lvl_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      on_r  <= on_eval;
      lvl_r <= lvl_eval;
    end else if (cmd.blend) begin
      lvl_r <= lvl_blend;
    end
  end

  // finish: compare against what is shown, fill output register
  logic          shown_on;
  logic [LW-1:0] shown_level;
  logic [LW-1:0] diff;
  logic          pchg, lupd;

  assign diff = (lvl_r > shown_level) ? lvl_r - shown_level : shown_level - lvl_r;
  assign pchg = (on_r != shown_on);
  assign lupd = pchg ? on_r : (on_r && (diff > bsd_pkg::LEVEL_STEP));

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_on    <= 1'b1;
      shown_level <= bsd_pkg::LEVEL_MAX;
    end else if (cmd.finish) begin
      shown_on <= on_r;
      if (lupd) shown_level <= lvl_r;
    end
  end

  logic          o_on, o_pchg, o_lupd;
  logic [LW-1:0] o_level;

  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_on    <= on_r;
      o_pchg  <= pchg;
      o_lupd  <= lupd;
      o_level <= lupd ? lvl_r : '0;
    end
  end

  assign out_data = {{(bsd_pkg::OUT_DATA_W-LW){1'b0}}, o_level};
  assign out_user = {o_lupd, o_pchg, o_on};

`ifndef NO_ASSERTIONS
  a_level_gated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (o_lupd || o_level == '0))
    else $error("level present without level update");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (o_level <= bsd_pkg::LEVEL_MAX))
    else $error("level beyond full scale");
  a_poweron_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_pchg && o_on) |-> o_lupd)
    else $error("power-on without level update");
  a_off_no_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !o_on) |-> !o_lupd)
    else $error("level update while display off");
`endif

endmodule

`default_nettype wire

// ===== test/backlight_schedule_dimmer_tb.sv =====
// Self-checking testbench for backlight_schedule_dimmer_top: drives ticks and register
// writes, predicts every display setting and compares each result beat field by field.
// Depends on bsd_pkg and the RTL of backlight_schedule_dimmer_top.
`timescale 1ns / 1ps

typedef struct packed {
  logic [bsd_pkg::TIME_W-1:0]  now;
  logic                        touched;
  logic [bsd_pkg::TOD_W-1:0]   tod;
  logic [bsd_pkg::PHASE_W-1:0] phase;
  logic [bsd_pkg::TOD_W-1:0]   snow;
  logic [bsd_pkg::TOD_W-1:0]   snoon;
  logic [bsd_pkg::TOD_W-1:0]   srise;
  logic [bsd_pkg::TOD_W-1:0]   sset;
} tick_t;

typedef struct packed {
  logic                        display_on;
  logic                        power_changed;
  logic                        level_update;
  logic [bsd_pkg::LEVEL_W-1:0] level;
} setting_t;

localparam logic [bsd_pkg::PHASE_W-1:0] PH_DAWN_NAUT   = 4'd2;
localparam logic [bsd_pkg::PHASE_W-1:0] PH_DUSK_NAUT   = 4'd7;
localparam logic [bsd_pkg::PHASE_W-1:0] PH_UNDEF_FIRST = 4'd10;
localparam logic [bsd_pkg::PHASE_W-1:0] PH_UNDEF_LAST  = 4'd15;

class dimmer_scoreboard;
  logic [bsd_pkg::LEVEL_W-1:0] night_lvl    = bsd_pkg::NIGHT_RST;
  logic [bsd_pkg::LEVEL_W-1:0] twilight_lvl = bsd_pkg::TWILIGHT_RST;
  logic [bsd_pkg::LEVEL_W-1:0] noon_lvl     = bsd_pkg::NOON_RST;
  logic [bsd_pkg::LEVEL_W-1:0] touch_lvl    = bsd_pkg::TOUCH_RST;
  logic [bsd_pkg::HOLD_W-1:0]  hold_ms      = bsd_pkg::HOLD_RST;
  logic [bsd_pkg::TOD_W-1:0]   on_start     = bsd_pkg::START_RST;
  logic [bsd_pkg::TOD_W-1:0]   on_end       = bsd_pkg::END_RST;

  logic [bsd_pkg::TIME_W-1:0]  last_touch   = '0;
  logic                        shown_on     = 1'b1;
  logic [bsd_pkg::LEVEL_W-1:0] shown_level  = bsd_pkg::LEVEL_MAX;

  setting_t due_settings[$];
  int       fails = 0;

  function void set_reg(bsd_pkg::cfg_idx_t idx, logic [bsd_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      bsd_pkg::REG_NIGHT:    night_lvl    = v[bsd_pkg::LEVEL_W-1:0];
      bsd_pkg::REG_TWILIGHT: twilight_lvl = v[bsd_pkg::LEVEL_W-1:0];
      bsd_pkg::REG_NOON:     noon_lvl     = v[bsd_pkg::LEVEL_W-1:0];
      bsd_pkg::REG_TOUCH:    touch_lvl    = v[bsd_pkg::LEVEL_W-1:0];
      bsd_pkg::REG_HOLD:     hold_ms      = v[bsd_pkg::HOLD_W-1:0];
      bsd_pkg::REG_START:    on_start     = v;
      bsd_pkg::REG_END:      on_end       = v;
      default: ;
    endcase
  endfunction

  function logic [bsd_pkg::LEVEL_W-1:0] cap_level(logic [bsd_pkg::LEVEL_W-1:0] v);
    return (v > bsd_pkg::LEVEL_MAX) ? bsd_pkg::LEVEL_MAX : v;
  endfunction

  // Blend from twilight towards noon, rounding halves away from zero, then saturate.
  function logic [bsd_pkg::LEVEL_W-1:0] blend_level(longint num, longint den);
    longint tw, prod, mag_p, mag_d, q, v;
    if (den == 0) return cap_level(noon_lvl);
    tw    = longint'(twilight_lvl);
    prod  = num * (longint'(noon_lvl) - tw);
    mag_p = (prod < 0) ? -prod : prod;
    mag_d = (den < 0) ? -den : den;
    q     = (2 * mag_p + mag_d) / (2 * mag_d);
    if ((prod < 0) != (den < 0)) q = -q;
    v = tw + q;
    if (v < 0) return '0;
    if (v > longint'(bsd_pkg::LEVEL_MAX)) return bsd_pkg::LEVEL_MAX;
    return v[bsd_pkg::LEVEL_W-1:0];
  endfunction

  function void predict_tick(tick_t t);
    logic                        on;
    logic [bsd_pkg::LEVEL_W-1:0] lvl;
    logic [bsd_pkg::LEVEL_W-1:0] step;
    logic [bsd_pkg::TIME_W:0]    hold_end;
    setting_t                    s;
    s = '0;
    if (t.touched) last_touch = t.now;
    // widen by one bit so the hold window never wraps
    hold_end = {1'b0, last_touch} + {{(bsd_pkg::TIME_W + 1 - bsd_pkg::HOLD_W){1'b0}}, hold_ms};
    if ({1'b0, t.now} < hold_end) begin
      on  = 1'b1;
      lvl = cap_level(touch_lvl);
    end else if (t.tod < on_start || t.tod > on_end) begin
      on  = 1'b0;
      lvl = '0;
    end else begin
      on = 1'b1;
      case (t.phase)
        bsd_pkg::PH_MORNING, bsd_pkg::PH_EVENING:
          lvl = cap_level(night_lvl);
        bsd_pkg::PH_DAWN_ASTRO, PH_DAWN_NAUT, bsd_pkg::PH_DAWN_CIVIL,
        bsd_pkg::PH_DUSK_CIVIL, PH_DUSK_NAUT, bsd_pkg::PH_DUSK_ASTRO:
          lvl = cap_level(twilight_lvl);
        bsd_pkg::PH_FORENOON:
          lvl = blend_level(longint'(t.snow) - longint'(t.srise),
                            longint'(t.snoon) - longint'(t.srise));
        bsd_pkg::PH_AFTERNOON:
          lvl = blend_level(longint'(t.sset) - longint'(t.snow),
                            longint'(t.sset) - longint'(t.snoon));
        default:
          lvl = '0;
      endcase
    end
    s.display_on = on;
    if (on != shown_on) begin
      s.power_changed = 1'b1;
      shown_on = on;
      if (on) begin
        s.level_update = 1'b1;
        s.level        = lvl;
        shown_level    = lvl;
      end
    end else if (on) begin
      step = (lvl > shown_level) ? lvl - shown_level : shown_level - lvl;
      if (step > bsd_pkg::LEVEL_STEP) begin
        s.level_update = 1'b1;
        s.level        = lvl;
        shown_level    = lvl;
      end
    end
    due_settings.push_back(s);
  endfunction

  function void check_setting(setting_t got);
    setting_t want;
    if (due_settings.size() == 0) begin
      $error("result beat with no setting outstanding");
      fails++;
      return;
    end
    want = due_settings.pop_front();
    if (got.display_on !== want.display_on) begin
      $error("display_on: expected %0d, got %0d", want.display_on, got.display_on);
      fails++;
    end
    if (got.power_changed !== want.power_changed) begin
      $error("power_changed: expected %0d, got %0d", want.power_changed, got.power_changed);
      fails++;
    end
    if (got.level_update !== want.level_update) begin
      $error("level_update: expected %0d, got %0d", want.level_update, got.level_update);
      fails++;
    end
    if (got.level !== want.level) begin
      $error("level: expected %0d, got %0d", want.level, got.level);
      fails++;
    end
  endfunction

  function int outstanding();
    return due_settings.size();
  endfunction
endclass

module testbench;
  localparam int unsigned DAY_LAST      = 86399999;
  localparam int unsigned NOON_TOD      = 43200000;
  localparam int unsigned RISE_TOD      = 21600000;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          QUIET_LIMIT   = 3000;
  localparam int          RAND_PHASES   = 7;
  localparam int          PHASE_TICKS   = 75;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [bsd_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [bsd_pkg::IN_USER_W-1:0]  s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [bsd_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [bsd_pkg::OUT_USER_W-1:0] m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data;

  dimmer_scoreboard dimmer = new();
  logic [bsd_pkg::TIME_W-1:0] wall_ms;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   rx_hold_req = 0;
  int   quiet_cycles = 0;

  backlight_schedule_dimmer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("backlight_schedule_dimmer_top test failed");
        $finish;
      end
    end
  end

  function automatic tick_t tick_at(logic [bsd_pkg::TIME_W-1:0] now, logic touched,
                                    logic [bsd_pkg::PHASE_W-1:0] phase,
                                    int unsigned snow, int unsigned snoon,
                                    int unsigned srise, int unsigned sset);
    tick_t t;
    t.now     = now;
    t.touched = touched;
    t.tod     = 27'(NOON_TOD);
    t.phase   = phase;
    t.snow    = 27'(snow);
    t.snoon   = 27'(snoon);
    t.srise   = 27'(srise);
    t.sset    = 27'(sset);
    return t;
  endfunction

  function automatic logic [bsd_pkg::TOD_W-1:0] any_tod();
    return 27'($urandom_range(0, DAY_LAST));
  endfunction

  // Mostly plausible days with a running clock; one tick in sixteen is pure noise.
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned rise, noon_t, set_t, pick;
    longint      pivot;
    if ($urandom_range(0, 15) == 0) begin
      t.now     = 40'({$urandom(), $urandom()});
      t.touched = 1'($urandom_range(0, 1));
      t.tod     = any_tod();
      t.phase   = 4'($urandom_range(0, 15));
      t.snow    = any_tod();
      t.snoon   = any_tod();
      t.srise   = any_tod();
      t.sset    = any_tod();
      return t;
    end
    if ($urandom_range(0, 3) == 0)
      wall_ms = wall_ms + 40'($urandom_range(0, 2 * dimmer.hold_ms + 2));
    else
      wall_ms = wall_ms + 40'($urandom_range(0, 2000));
    t.now     = wall_ms;
    t.touched = ($urandom_range(0, 7) == 0);
    rise   = $urandom_range(14400000, 28800000);
    noon_t = $urandom_range(39600000, 46800000);
    set_t  = $urandom_range(57600000, 72000000);
    case ($urandom_range(0, 15))
      0: noon_t = rise;
      1: set_t  = noon_t;
      default: ;
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 8)
      t.phase = bsd_pkg::PH_FORENOON;
    else if (pick < 16)
      t.phase = bsd_pkg::PH_AFTERNOON;
    else if (pick < 19)
      t.phase = 4'($urandom_range(bsd_pkg::PH_MORNING, bsd_pkg::PH_EVENING));
    else
      t.phase = 4'($urandom_range(PH_UNDEF_FIRST, PH_UNDEF_LAST));
    if ($urandom_range(0, 7) == 0)
      t.snow = any_tod();
    else if (t.phase == bsd_pkg::PH_FORENOON)
      t.snow = 27'($urandom_range(rise, noon_t));
    else
      t.snow = 27'($urandom_range(noon_t, set_t));
    t.snoon = 27'(noon_t);
    t.srise = 27'(rise);
    t.sset  = 27'(set_t);
    // land on either side of the window bounds now and then
    case ($urandom_range(0, 7))
      0: pivot = longint'(dimmer.on_start);
      1: pivot = longint'(dimmer.on_end);
      default: pivot = -1;
    endcase
    if (pivot < 0) begin
      t.tod = any_tod();
    end else begin
      pivot = pivot + longint'($urandom_range(0, 2)) - 1;
      if (pivot < 0) pivot = 0;
      if (pivot > longint'(DAY_LAST)) pivot = longint'(DAY_LAST);
      t.tod = pivot[bsd_pkg::TOD_W-1:0];
    end
    return t;
  endfunction

  function automatic int tx_gap();
    return tx_steady ? 0 : $urandom_range(0, 15);
  endfunction

  // Called and returning at a falling edge; valid stays up for a back-to-back beat.
  task automatic send_tick(tick_t t, int gap);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {1'b0, t.sset, t.srise, t.snoon, t.snow, t.tod, t.now};
    s_tuser  = {t.phase, t.touched};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    dimmer.predict_tick(t);
    @(negedge clk);
  endtask

  task automatic write_reg(bsd_pkg::cfg_idx_t idx, int unsigned value);
    cfg_index = idx;
    cfg_data  = value[bsd_pkg::CFG_DATA_W-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    dimmer.set_reg(idx, value[bsd_pkg::CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(int unsigned night, int unsigned twilight, int unsigned noon,
                           int unsigned touch, int unsigned hold,
                           int unsigned start_ms, int unsigned end_ms);
    write_reg(bsd_pkg::REG_NIGHT, night);
    write_reg(bsd_pkg::REG_TWILIGHT, twilight);
    write_reg(bsd_pkg::REG_NOON, noon);
    write_reg(bsd_pkg::REG_TOUCH, touch);
    write_reg(bsd_pkg::REG_HOLD, hold);
    write_reg(bsd_pkg::REG_START, start_ms);
    write_reg(bsd_pkg::REG_END, end_ms);
  endtask

  // Drop valid and hold until every predicted setting has come back.
  task automatic settle();
    s_tvalid = 1'b0;
    while (dimmer.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : receiver
    int       stall;
    int       served;
    setting_t got;
    served   = 0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (served % 25 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 15);
      if (rx_hold_req != 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.display_on    = m_tuser[0];
      got.power_changed = m_tuser[1];
      got.level_update  = m_tuser[2];
      got.level         = m_tdata[bsd_pkg::LEVEL_W-1:0];
      dimmer.check_setting(got);
      served++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int ph;
    int i;
    int gap;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = bsd_pkg::REG_NIGHT;
    cfg_data  = '0;
    wall_ms   = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Reset settings: touch time starts at zero, so the first ticks are held.
    send_tick(tick_at(40'd0, 1'b0, bsd_pkg::PH_MORNING, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd29999, 1'b0, bsd_pkg::PH_EVENING, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd30000, 1'b0, bsd_pkg::PH_MORNING, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd40000, 1'b0, bsd_pkg::PH_DAWN_ASTRO, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd40001, 1'b0, PH_DAWN_NAUT, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd40002, 1'b0, bsd_pkg::PH_DAWN_CIVIL, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd40003, 1'b0, bsd_pkg::PH_DUSK_CIVIL, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd40004, 1'b0, PH_DUSK_NAUT, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd40005, 1'b0, bsd_pkg::PH_DUSK_ASTRO, 0, 0, 0, 0), tx_gap());
    // step of exactly ten is held back, eleven goes out
    send_tick(tick_at(40'd50000, 1'b0, bsd_pkg::PH_FORENOON,
                      RISE_TOD + 10, RISE_TOD + 600, RISE_TOD, DAY_LAST), tx_gap());
    send_tick(tick_at(40'd50001, 1'b0, bsd_pkg::PH_FORENOON,
                      RISE_TOD + 11, RISE_TOD + 600, RISE_TOD, DAY_LAST), tx_gap());
    send_tick(tick_at(40'd50002, 1'b0, bsd_pkg::PH_FORENOON,
                      RISE_TOD + 11, RISE_TOD, RISE_TOD, DAY_LAST), tx_gap());
    send_tick(tick_at(40'd50003, 1'b0, bsd_pkg::PH_FORENOON,
                      RISE_TOD - 600, RISE_TOD + 600, RISE_TOD, DAY_LAST), tx_gap());
    // half-way quotients, below and above zero
    send_tick(tick_at(40'd50004, 1'b0, bsd_pkg::PH_AFTERNOON,
                      NOON_TOD + 1201, NOON_TOD, 0, NOON_TOD + 1200), tx_gap());
    send_tick(tick_at(40'd50005, 1'b0, bsd_pkg::PH_AFTERNOON,
                      NOON_TOD + 599, NOON_TOD, 0, NOON_TOD + 1200), tx_gap());
    send_tick(tick_at(40'd50006, 1'b0, bsd_pkg::PH_AFTERNOON,
                      NOON_TOD - 1200, NOON_TOD, 0, NOON_TOD + 1200), tx_gap());
    send_tick(tick_at(40'd50007, 1'b0, bsd_pkg::PH_AFTERNOON,
                      DAY_LAST, DAY_LAST, DAY_LAST, DAY_LAST), tx_gap());
    send_tick(tick_at(40'd50008, 1'b0, PH_UNDEF_FIRST, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd50009, 1'b0, PH_UNDEF_LAST, 0, 0, 0, 0), tx_gap());
    // touch at the top of the clock must not wrap the hold window
    send_tick(tick_at(40'hFF_FFFF_FFFF, 1'b1, bsd_pkg::PH_MORNING, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'h00_0000_1000, 1'b0, bsd_pkg::PH_MORNING, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd1000000, 1'b1, bsd_pkg::PH_EVENING, 0, 0, 0, 0), tx_gap());
    send_tick(tick_at(40'd1030000, 1'b0, bsd_pkg::PH_EVENING, 0, 0, 0, 0), tx_gap());

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: write_all(0, 1000, 0, 0, 0, 0, DAY_LAST);
          2: write_all(1023, 1023, 1023, 1023, 3600000, NOON_TOD, NOON_TOD - 1);
          3: write_all(1000, 0, 1000, 500, 1, DAY_LAST, DAY_LAST);
          default:
            write_all($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 60000), $urandom_range(0, NOON_TOD),
                      $urandom_range(NOON_TOD, DAY_LAST));
        endcase
      end
      wall_ms = 40'({$urandom(), $urandom()});
      for (i = 0; i < PHASE_TICKS; i++) begin
        if (i % 25 == 0) tx_steady = ($urandom_range(0, 2) == 0);
        gap = tx_gap();
        // stall the sink for a long stretch while ticks keep coming back to back
        if (ph == 4 && i == 20) rx_hold_req = 400;
        if (ph == 4 && i >= 20 && i < 32) gap = 0;
        send_tick(random_tick(), gap);
      end
    end

    settle();
    if (dimmer.fails == 0)
      $display("backlight_schedule_dimmer_top test passed");
    else
      $display("backlight_schedule_dimmer_top test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/bsd_pkg.sv
rtl/core/bsd_ctrl.sv
rtl/core/bsd_dp.sv
rtl/core/backlight_schedule_dimmer_top.sv
test/backlight_schedule_dimmer_tb.sv
